### hw/rtl/hs_pkg.sv
package hs_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = ADDR_W + 1;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_set;
    logic               overflowed;
  } out_word_t;

  // Source of the value written into the store.
  typedef enum logic [1:0] {
    WR_IN,
    WR_HELD,
    WR_CAND,
    WR_RDATA
  } wr_src_e;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_src_e           wr_sel;
    logic              ld_held;
    logic              ld_cand;
  } hs_cmd_t;

  typedef struct packed {
    logic cand_lt_rd;
    logic held_gt_cand;
  } hs_sts_t;

endpackage

### hw/rtl/hs_datapath.sv
// Store, read register and the two value registers used while sifting.
module hs_datapath import hs_pkg::*; (
  input  logic               clk_i,
  input  hs_cmd_t            cmd_i,
  input  logic signed [31:0] value_i,
  output hs_sts_t            sts_o,
  output logic signed [31:0] rdata_o
);

  logic signed [31:0] mem_q [CAPACITY];
  logic signed [31:0] rdata_q;
  logic signed [31:0] held_q;
  logic signed [31:0] cand_q;
  logic signed [31:0] wdata;

  always_comb begin
    case (cmd_i.wr_sel)
      WR_IN:    wdata = value_i;
      WR_HELD:  wdata = held_q;
      WR_CAND:  wdata = cand_q;
      WR_RDATA: wdata = rdata_q;
      default:  wdata = value_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_held) begin
      held_q <= rdata_q;
    end
    if (cmd_i.ld_cand) begin
      cand_q <= rdata_q;
    end
  end

  assign sts_o.cand_lt_rd   = cand_q < rdata_q;
  assign sts_o.held_gt_cand = held_q > cand_q;
  assign rdata_o            = rdata_q;

endmodule

### hw/rtl/hs_ctrl.sv
// Sequencer for loading, heap build, extraction and read-out.
module hs_ctrl import hs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    is_last_i,
  output logic    busy_o,
  output hs_cmd_t cmd_o,
  input  hs_sts_t sts_i,
  output logic    strobe_o,
  output logic    fin_o,
  output logic    ovf_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_RDH,
    ST_HELD,
    ST_KID,
    ST_RD2,
    ST_CMP2,
    ST_CMP,
    ST_EXT,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_SW3,
    ST_OUT,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic              dropped_q;
  logic [ADDR_W-1:0] s_q;
  logic [CNT_W-1:0]  last_q;
  logic [CNT_W-1:0]  lim_q;
  logic [ADDR_W-1:0] hole_q;
  logic [ADDR_W-1:0] kid_q;
  logic              extract_q;
  logic [ADDR_W-1:0] k_q;
  logic              strobe_q;
  logic              fin_q;
  logic              ovf_q;

  logic             full;
  logic [CNT_W-1:0] cnt_n;
  logic [CNT_W-1:0] kid_w;
  logic [CNT_W-1:0] kid1_w;
  logic             out_fin;

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign cnt_n   = full ? count_q : count_q + CNT_W'(1);
  assign kid_w   = {hole_q, 1'b1};
  assign kid1_w  = {1'b0, kid_q} + CNT_W'(1);
  assign out_fin = (({1'b0, k_q} + CNT_W'(1)) == count_q);

  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_sel  = WR_IN;
    case (state_q)
      ST_IDLE: begin
        cmd_o.wr_en   = start_i && !full;
        cmd_o.wr_addr = count_q[ADDR_W-1:0];
      end
      ST_RDH: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = hole_q;
      end
      ST_HELD: begin
        cmd_o.ld_held = 1'b1;
      end
      ST_KID: begin
        if (kid_w >= lim_q) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = hole_q;
          cmd_o.wr_sel  = WR_HELD;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = kid_w[ADDR_W-1:0];
        end
      end
      ST_RD2: begin
        cmd_o.ld_cand = 1'b1;
        if (kid1_w < lim_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = kid1_w[ADDR_W-1:0];
        end
      end
      ST_CMP2: begin
        cmd_o.ld_cand = sts_i.cand_lt_rd;
      end
      ST_CMP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = hole_q;
        cmd_o.wr_sel  = sts_i.held_gt_cand ? WR_HELD : WR_CAND;
      end
      ST_SW0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
      end
      ST_SW1: begin
        cmd_o.ld_cand = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = last_q[ADDR_W-1:0];
      end
      ST_SW2: begin
        cmd_o.ld_held = 1'b1;
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = '0;
        cmd_o.wr_sel  = WR_RDATA;
      end
      ST_SW3: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = last_q[ADDR_W-1:0];
        cmd_o.wr_sel  = WR_CAND;
      end
      ST_OUT: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = k_q;
      end
      default: begin
        cmd_o.rd_en   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      dropped_q <= 1'b0;
      s_q       <= '0;
      last_q    <= '0;
      lim_q     <= '0;
      hole_q    <= '0;
      kid_q     <= '0;
      extract_q <= 1'b0;
      k_q       <= '0;
      strobe_q  <= 1'b0;
      fin_q     <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            count_q <= cnt_n;
            if (full) begin
              dropped_q <= 1'b1;
            end
            if (is_last_i) begin
              s_q     <= cnt_n[CNT_W-1:1] + ADDR_W'(1);
              last_q  <= cnt_n;
              state_q <= ST_BUILD;
            end
          end
        end
        ST_BUILD: begin
          if (s_q == '0) begin
            state_q <= ST_EXT;
          end else begin
            s_q       <= s_q - ADDR_W'(1);
            hole_q    <= s_q - ADDR_W'(1);
            lim_q     <= count_q;
            extract_q <= 1'b0;
            state_q   <= ST_RDH;
          end
        end
        ST_RDH:  state_q <= ST_HELD;
        ST_HELD: state_q <= ST_KID;
        ST_KID: begin
          if (kid_w >= lim_q) begin
            state_q <= extract_q ? ST_EXT : ST_BUILD;
          end else begin
            kid_q   <= kid_w[ADDR_W-1:0];
            state_q <= ST_RD2;
          end
        end
        ST_RD2: begin
          state_q <= (kid1_w < lim_q) ? ST_CMP2 : ST_CMP;
        end
        ST_CMP2: begin
          if (sts_i.cand_lt_rd) begin
            kid_q <= kid1_w[ADDR_W-1:0];
          end
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (sts_i.held_gt_cand) begin
            state_q <= extract_q ? ST_EXT : ST_BUILD;
          end else begin
            hole_q  <= kid_q;
            state_q <= ST_KID;
          end
        end
        ST_EXT: begin
          if (last_q > CNT_W'(1)) begin
            last_q  <= last_q - CNT_W'(1);
            state_q <= ST_SW0;
          end else begin
            k_q     <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_SW0: state_q <= ST_SW1;
        ST_SW1: state_q <= ST_SW2;
        ST_SW2: state_q <= ST_SW3;
        ST_SW3: begin
          hole_q    <= '0;
          lim_q     <= last_q;
          extract_q <= 1'b1;
          state_q   <= ST_KID;
        end
        ST_OUT: begin
          strobe_q <= 1'b1;
          fin_q    <= out_fin;
          ovf_q    <= out_fin & dropped_q;
          k_q      <= k_q + ADDR_W'(1);
          if (out_fin) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          count_q   <= '0;
          dropped_q <= 1'b0;
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign fin_o    = fin_q;
  assign ovf_o    = ovf_q;

endmodule

### hw/rtl/heap_sorter_core.sv
// Heap sorter for sets of up to 64 signed 32-bit values. A word is taken
// whenever start_i is high while busy_o is low; it is written into the store
// in that cycle, so loading runs at one word per clock. The word that carries
// is_last closes the set: busy_o then rises and the block builds a max-heap,
// extracts it in place and streams the set out smallest first, one result
// word per clock on out_o while out_strobe_o is high. The receiver cannot
// stall: every result word is valid for exactly one cycle and must be taken
// then. The final word of the set carries end_of_set, and overflowed on that
// word reports that values arrived while the store was full and were
// dropped. Sorting cost is set by the store, which the controller uses for
// one access per step: each sift level reads the left child, reads the
// right child and picks the larger when there is one, then compares and
// writes back, and a sift that runs out of children writes the held value
// back. Each heap-build sift first reads and holds the entry to be sifted,
// and each extraction step steps the heap end and swaps root and last
// entry before its sift.
// busy_o falls in the cycle after the word that carries end_of_set.
module heap_sorter_core import hs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  in_i,
  output logic      busy_o,
  output logic      out_strobe_o,
  output out_word_t out_o
);

  hs_cmd_t            cmd;
  hs_sts_t            sts;
  logic signed [31:0] rdata;
  logic               fin;
  logic               ovf;

  // The controller owns all indices and the set bookkeeping.
  hs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .is_last_i (in_i.is_last),
    .busy_o    (busy_o),
    .cmd_o     (cmd),
    .sts_i     (sts),
    .strobe_o  (out_strobe_o),
    .fin_o     (fin),
    .ovf_o     (ovf)
  );

  // The datapath holds the store and the values being compared.
  hs_datapath u_datapath (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .value_i (in_i.value),
    .sts_o   (sts),
    .rdata_o (rdata)
  );

  // Read-out: the registered store output lines up with the strobe.
  assign out_o.sorted_value = rdata;
  assign out_o.end_of_set   = fin;
  assign out_o.overflowed   = ovf;

  // The block returns to idle straight after the last word of a set.
  a_idle_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && out_o.end_of_set |=> !busy_o)
    else $error("block still busy after end of set");

  // Results only appear while a set is being processed.
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !out_strobe_o)
    else $error("result word while idle");

  // Overflow is only reported on the closing word.
  a_ovf_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && out_o.overflowed |-> out_o.end_of_set)
    else $error("overflow flag on a word other than the last");

  // A word accepted without is_last never starts the sort.
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !in_i.is_last |=> !busy_o)
    else $error("block left idle on a word that does not close the set");

endmodule
